@@ rtl/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Types, widths and codes shared by the k-medoids clustering block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int MAX_FEATURES = 8;
  localparam int MAX_CLUSTERS = 8;

  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int FIDX_W  = $clog2(MAX_FEATURES);
  localparam int CIDX_W  = $clog2(MAX_CLUSTERS);
  localparam int CNT_P_W = PIDX_W + 1;
  localparam int CNT_F_W = FIDX_W + 1;
  localparam int CNT_C_W = CIDX_W + 1;
  localparam int IT_W    = 8;

  localparam int RAW_AW    = PIDX_W + FIDX_W;
  localparam int RAW_DEPTH = MAX_POINTS * MAX_FEATURES;
  localparam int MED_AW    = CIDX_W + FIDX_W;
  localparam int MED_DEPTH = MAX_CLUSTERS * MAX_FEATURES;

  localparam int VAL_W     = 16;
  localparam int SUM_W     = VAL_W + PIDX_W;
  localparam int SQ_W      = 2 * VAL_W - 1;
  localparam int SUMSQ_W   = SQ_W + PIDX_W;
  localparam int VAR_W     = SUMSQ_W + CNT_P_W;
  localparam int ROOT_W    = VAR_W / 2;
  localparam int NUM_W     = VAL_W + CNT_P_W + 1;
  localparam int FRAC_BITS = 12;
  localparam int DVD_W     = NUM_W - 1 + FRAC_BITS;
  localparam int DVS_W     = ROOT_W;
  localparam int DIST_W    = 2 * (VAL_W + 1);
  localparam int ACC_W     = DIST_W + FIDX_W;

  localparam int ZMAX = 32767;
  localparam int ZMIN_MAG = 32768;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd3;

  localparam logic [1:0] CMD_LOAD_FEATURE = 2'd0;
  localparam logic [1:0] CMD_LOAD_MEDOID  = 2'd1;
  localparam logic [1:0] CMD_RUN          = 2'd2;
  localparam logic [1:0] CMD_NOP          = 2'd3;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] feature_value;
    logic [PIDX_W-1:0]       medoid_point;
  } cmd_t;

  typedef struct packed {
    logic [PIDX_W-1:0] point_index;
    logic [CIDX_W-1:0] cluster_label;
    logic              converged;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/kmc_div.sv @@
// ----------------------------------------------------------------------------
// kmc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_div
  import kmc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DVS_W:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DVD_W-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ rtl/kmc_sqrt.sv @@
// ----------------------------------------------------------------------------
// kmc_sqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_sqrt
  import kmc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [VAR_W-1:0]  radicand_i,
  output logic      [ROOT_W-1:0] root_o,
  output logic                   done_o
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [VAR_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+1:0] rem_q, rem_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              run_q, run_d, done_q, done_d;
  logic [ROOT_W+3:0] rem_sh, trial;

  always_comb begin
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = {rem_q, rad_q[VAR_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i) begin
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d = {rad_q[VAR_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = (ROOT_W + 2)'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(ROOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ rtl/kmedoids_clustering.sv @@
// ----------------------------------------------------------------------------
// kmedoids_clustering
// K-medoids (Voronoi iteration) over z-scored Q3.12 features.
// ----------------------------------------------------------------------------
// channel   direction  transfer
// command   in         start & !busy
// result    out        result_valid_o (one cycle, no backpressure)
// config    in         cfg_valid_i & cfg_ready_o (always ready)
//
// Load commands store one value each. A run walks the stored points through
// registered-read memories; scaling uses the serial divider for each value
// whose feature spread is nonzero, and each pass runs the assignment plus the
// medoid search. Results then follow in point order.
// Reset clears control and counters only; the data memories need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module kmedoids_clustering
  import kmc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmd_t                  cmd_i,
  output logic                       result_valid_o,
  output res_t                       result_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_STAT   = 5'd1;
  localparam logic [4:0] S_VAR0   = 5'd2;
  localparam logic [4:0] S_VAR1   = 5'd3;
  localparam logic [4:0] S_SQRT   = 5'd4;
  localparam logic [4:0] S_ZRD    = 5'd5;
  localparam logic [4:0] S_ZST    = 5'd6;
  localparam logic [4:0] S_ZDIV   = 5'd7;
  localparam logic [4:0] S_INIT   = 5'd8;
  localparam logic [4:0] S_ICPY   = 5'd9;
  localparam logic [4:0] S_ASN    = 5'd10;
  localparam logic [4:0] S_ACMP   = 5'd11;
  localparam logic [4:0] S_ALBL   = 5'd12;
  localparam logic [4:0] S_ADONE  = 5'd13;
  localparam logic [4:0] S_UPD    = 5'd14;
  localparam logic [4:0] S_MSUM   = 5'd15;
  localparam logic [4:0] S_MSTART = 5'd16;
  localparam logic [4:0] S_MDIV   = 5'd17;
  localparam logic [4:0] S_MSRCH  = 5'd18;
  localparam logic [4:0] S_MDST   = 5'd19;
  localparam logic [4:0] S_MCMP   = 5'd20;
  localparam logic [4:0] S_MCPY   = 5'd21;
  localparam logic [4:0] S_OUT    = 5'd22;

  // configuration
  logic [CNT_P_W-1:0] num_points_q;
  logic [CNT_F_W-1:0] num_features_q;
  logic [CNT_C_W-1:0] num_clusters_q;
  logic [IT_W-1:0]    max_iter_q;

  // memories
  logic [VAL_W-1:0]  raw_mem  [RAW_DEPTH];
  logic [VAL_W-1:0]  smem     [RAW_DEPTH];
  logic [VAL_W-1:0]  med_mem  [MED_DEPTH];
  logic [VAL_W-1:0]  mean_mem [MED_DEPTH];
  logic [CIDX_W-1:0] lbl_mem  [MAX_POINTS];
  logic [VAL_W-1:0]  raw_rd_q, smem_rd_q, med_rd_q, mean_rd_q;
  logic [CIDX_W-1:0] lbl_rd_q;

  logic              raw_we, smem_we, med_we, mean_we, lbl_we;
  logic [RAW_AW-1:0] smem_raddr, smem_waddr;
  logic [MED_AW-1:0] cj_addr;
  logic [VAL_W-1:0]  smem_wdata, mean_wdata;

  logic [PIDX_W-1:0] init_idx_q [MAX_CLUSTERS];
  logic              init_we;

  logic [CNT_P_W-1:0] size_q [MAX_CLUSTERS];
  logic [CNT_P_W-1:0] size_d [MAX_CLUSTERS];
  logic               size_clr, size_inc;

  logic [4:0]          state_q, state_d;
  logic                ph_q, ph_d;
  logic [CNT_P_W-1:0]  p_q, p_d, n_q, n_d;
  logic [CNT_F_W-1:0]  j_q, j_d, nf_q, nf_d;
  logic [CNT_C_W-1:0]  c_q, c_d, k_q, k_d;
  logic [IT_W-1:0]     it_q, it_d, iters_q, iters_d;
  logic [RAW_AW-1:0]   raw_addr_q, raw_addr_d, load_pos_q, load_pos_d;
  logic [CIDX_W-1:0]   mload_pos_q, mload_pos_d;
  logic signed [SUM_W-1:0] sum_q, sum_d, msum_q, msum_d;
  logic [SUMSQ_W-1:0]  sumsq_q, sumsq_d;
  logic [VAR_W-1:0]    prod1_q, prod1_d, prod2_q, prod2_d;
  logic [ROOT_W-1:0]   s_q, s_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic [ACC_W-1:0]    acc_q, acc_d, bd_q, bd_d;
  logic [CIDX_W-1:0]   best_c_q, best_c_d;
  logic [PIDX_W-1:0]   best_p_q, best_p_d, midx_q, midx_d;
  logic                first_q, first_d, changed_q, changed_d, found_q, found_d;
  logic                conv_q, conv_d;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;

  // clamped settings
  logic [CNT_P_W-1:0] n_cl;
  logic [CNT_F_W-1:0] nf_cl;
  logic [CNT_C_W-1:0] k_cl, k_sat;
  logic [IT_W-1:0]    it_cl;

  // datapath
  logic signed [2*VAL_W-1:0]   xsq;
  logic signed [NUM_W-1:0]     nx, num_abs;
  logic signed [2*SUM_W-1:0]   sum2;
  logic signed [VAR_W:0]       var_s;
  logic [VAR_W-1:0]            radicand;
  logic signed [VAL_W:0]       dsub;
  logic signed [DIST_W-1:0]    dsq;
  logic [VAL_W-1:0]            other_rd;
  logic [SUM_W-1:0]            msum_abs;
  logic [DVD_W-1:0]            div_dvd, div_q;
  logic [DVS_W-1:0]            div_dvs;
  logic                        div_start, div_done, sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]           root;
  logic [VAL_W-1:0]            z_val;
  logic                        last_p, last_j, last_c, accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (num_points_q == '0) n_cl = CNT_P_W'(1);
    else if (num_points_q > CNT_P_W'(MAX_POINTS)) n_cl = CNT_P_W'(MAX_POINTS);
    else n_cl = num_points_q;
    if (num_features_q == '0) nf_cl = CNT_F_W'(1);
    else if (num_features_q > CNT_F_W'(MAX_FEATURES)) nf_cl = CNT_F_W'(MAX_FEATURES);
    else nf_cl = num_features_q;
    if (num_clusters_q == '0) k_cl = CNT_C_W'(1);
    else if (num_clusters_q > CNT_C_W'(MAX_CLUSTERS)) k_cl = CNT_C_W'(MAX_CLUSTERS);
    else k_cl = num_clusters_q;
    k_sat = (CNT_P_W'(k_cl) > n_cl) ? CNT_C_W'(n_cl) : k_cl;
    it_cl = (max_iter_q == '0) ? IT_W'(1) : max_iter_q;
  end

  assign last_p = (p_q == n_q - CNT_P_W'(1));
  assign last_j = (j_q == nf_q - CNT_F_W'(1));
  assign last_c = (c_q == k_q - CNT_C_W'(1));

  // arithmetic
  assign xsq      = $signed(raw_rd_q) * $signed(raw_rd_q);
  assign nx       = $signed({1'b0, n_q}) * $signed(raw_rd_q);
  assign sum2     = sum_q * sum_q;
  assign var_s    = $signed({1'b0, prod1_q}) - $signed({1'b0, prod2_q});
  assign radicand = var_s[VAR_W] ? '0 : var_s[VAR_W-1:0];
  assign num_abs  = num_q[NUM_W-1] ? -num_q : num_q;
  assign msum_abs = msum_q[SUM_W-1] ? SUM_W'(-msum_q) : SUM_W'(msum_q);
  assign other_rd = (state_q == S_MDST) ? mean_rd_q : med_rd_q;
  assign dsub     = $signed({smem_rd_q[VAL_W-1], smem_rd_q})
                  - $signed({other_rd[VAL_W-1], other_rd});
  assign dsq      = dsub * dsub;

  assign div_dvd = (state_q == S_MSTART) ? DVD_W'(msum_abs)
                                         : {num_abs[NUM_W-2:0], {FRAC_BITS{1'b0}}};
  assign div_dvs = (state_q == S_MSTART) ? DVS_W'(size_q[c_q[CIDX_W-1:0]]) : s_q;

  always_comb begin
    if (!num_q[NUM_W-1]) begin
      z_val = (div_q > DVD_W'(ZMAX)) ? VAL_W'(ZMAX) : div_q[VAL_W-1:0];
    end else begin
      z_val = (div_q > DVD_W'(ZMIN_MAG)) ? VAL_W'(ZMIN_MAG) : VAL_W'(-div_q[VAL_W-1:0]);
    end
  end

  assign mean_wdata = msum_q[SUM_W-1] ? VAL_W'(-div_q[VAL_W-1:0]) : div_q[VAL_W-1:0];
  assign cj_addr    = {c_q[CIDX_W-1:0], j_q[FIDX_W-1:0]};
  assign smem_waddr = {p_q[PIDX_W-1:0], j_q[FIDX_W-1:0]};

  always_comb begin
    unique case (state_q)
      S_ICPY:  smem_raddr = {midx_q, j_q[FIDX_W-1:0]};
      S_MCPY:  smem_raddr = {best_p_q, j_q[FIDX_W-1:0]};
      default: smem_raddr = {p_q[PIDX_W-1:0], j_q[FIDX_W-1:0]};
    endcase
  end

  kmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  kmc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    p_d         = p_q;
    j_d         = j_q;
    c_d         = c_q;
    it_d        = it_q;
    n_d         = n_q;
    nf_d        = nf_q;
    k_d         = k_q;
    iters_d     = iters_q;
    raw_addr_d  = raw_addr_q;
    load_pos_d  = load_pos_q;
    mload_pos_d = mload_pos_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    msum_d      = msum_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    s_d         = s_q;
    num_d       = num_q;
    acc_d       = acc_q;
    bd_d        = bd_q;
    best_c_d    = best_c_q;
    best_p_d    = best_p_q;
    midx_d      = midx_q;
    first_d     = first_q;
    changed_d   = changed_q;
    found_d     = found_q;
    conv_d      = conv_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    raw_we      = 1'b0;
    init_we     = 1'b0;
    smem_we     = 1'b0;
    smem_wdata  = z_val;
    med_we      = 1'b0;
    mean_we     = 1'b0;
    lbl_we      = 1'b0;
    size_clr    = 1'b0;
    size_inc    = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.command)
            CMD_LOAD_FEATURE: begin
              raw_we     = 1'b1;
              load_pos_d = load_pos_q + 1'b1;
            end
            CMD_LOAD_MEDOID: begin
              init_we     = 1'b1;
              mload_pos_d = mload_pos_q + 1'b1;
            end
            CMD_RUN: begin
              n_d        = n_cl;
              nf_d       = nf_cl;
              k_d        = k_sat;
              iters_d    = it_cl;
              p_d        = '0;
              j_d        = '0;
              raw_addr_d = '0;
              sum_d      = '0;
              sumsq_d    = '0;
              ph_d       = 1'b0;
              first_d    = 1'b1;
              conv_d     = 1'b0;
              state_d    = S_STAT;
            end
            default: ;
          endcase
        end
      end
      S_STAT: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d       = 1'b0;
          sum_d      = sum_q + {{(SUM_W-VAL_W){raw_rd_q[VAL_W-1]}}, raw_rd_q};
          sumsq_d    = sumsq_q + SUMSQ_W'(xsq[SQ_W-1:0]);
          raw_addr_d = raw_addr_q + RAW_AW'(nf_q);
          if (last_p) state_d = S_VAR0;
          else p_d = p_q + 1'b1;
        end
      end
      S_VAR0: begin
        prod1_d = VAR_W'(n_q * sumsq_q);
        prod2_d = VAR_W'(sum2);
        state_d = S_VAR1;
      end
      S_VAR1: begin
        sqrt_start = 1'b1;
        state_d    = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_done) begin
          s_d        = root;
          p_d        = '0;
          raw_addr_d = RAW_AW'(j_q);
          ph_d       = 1'b0;
          state_d    = S_ZRD;
        end
      end
      S_ZRD: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d    = 1'b0;
          num_d   = nx - {{(NUM_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
          state_d = S_ZST;
        end
      end
      S_ZST, S_ZDIV: begin
        if (state_q == S_ZST && s_q != '0) begin
          div_start = 1'b1;
          state_d   = S_ZDIV;
        end else if (state_q == S_ZST || div_done) begin
          smem_we    = 1'b1;
          smem_wdata = (state_q == S_ZST) ? '0 : z_val;
          raw_addr_d = raw_addr_q + RAW_AW'(nf_q);
          if (last_p) begin
            if (last_j) begin
              c_d     = '0;
              state_d = S_INIT;
            end else begin
              j_d        = j_q + 1'b1;
              p_d        = '0;
              raw_addr_d = RAW_AW'(j_q + 1'b1);
              sum_d      = '0;
              sumsq_d    = '0;
              state_d    = S_STAT;
            end
          end else begin
            p_d     = p_q + 1'b1;
            state_d = S_ZRD;
          end
        end
      end
      S_INIT: begin
        if (CNT_P_W'(init_idx_q[c_q[CIDX_W-1:0]]) >= n_q) begin
          midx_d = PIDX_W'(n_q - CNT_P_W'(1));
        end else begin
          midx_d = init_idx_q[c_q[CIDX_W-1:0]];
        end
        j_d     = '0;
        ph_d    = 1'b0;
        state_d = S_ICPY;
      end
      S_ICPY, S_MCPY: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d   = 1'b0;
          med_we = 1'b1;
          if (!last_j) begin
            j_d = j_q + 1'b1;
          end else if (!last_c) begin
            c_d     = c_q + 1'b1;
            state_d = (state_q == S_ICPY) ? S_INIT : S_UPD;
          end else begin
            p_d       = '0;
            c_d       = '0;
            j_d       = '0;
            acc_d     = '0;
            size_clr  = 1'b1;
            changed_d = 1'b0;
            state_d   = S_ASN;
          end
        end
      end
      S_ASN, S_MDST: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d  = 1'b0;
          acc_d = acc_q + ACC_W'(unsigned'(dsq));
          if (last_j) state_d = (state_q == S_ASN) ? S_ACMP : S_MCMP;
          else j_d = j_q + 1'b1;
        end
      end
      S_ACMP: begin
        if (c_q == '0 || acc_q <= bd_q) begin
          bd_d     = acc_q;
          best_c_d = c_q[CIDX_W-1:0];
        end
        acc_d = '0;
        j_d   = '0;
        if (last_c) begin
          state_d = S_ALBL;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_ASN;
        end
      end
      S_ALBL: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d     = 1'b0;
          lbl_we   = 1'b1;
          size_inc = 1'b1;
          if (lbl_rd_q != best_c_q) changed_d = 1'b1;
          if (last_p) begin
            state_d = S_ADONE;
          end else begin
            p_d     = p_q + 1'b1;
            c_d     = '0;
            j_d     = '0;
            state_d = S_ASN;
          end
        end
      end
      S_ADONE: begin
        c_d = '0;
        p_d = '0;
        if (first_q) begin
          first_d = 1'b0;
          it_d    = '0;
          state_d = S_UPD;
        end else if (!changed_q) begin
          conv_d  = 1'b1;
          state_d = S_OUT;
        end else if (it_q == iters_q - IT_W'(1)) begin
          state_d = S_OUT;
        end else begin
          it_d    = it_q + 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (size_q[c_q[CIDX_W-1:0]] == '0) begin
          if (last_c) begin
            p_d       = '0;
            c_d       = '0;
            j_d       = '0;
            acc_d     = '0;
            size_clr  = 1'b1;
            changed_d = 1'b0;
            state_d   = S_ASN;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          j_d     = '0;
          p_d     = '0;
          msum_d  = '0;
          ph_d    = 1'b0;
          state_d = S_MSUM;
        end
      end
      S_MSUM: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (lbl_rd_q == c_q[CIDX_W-1:0]) begin
            msum_d = msum_q + {{(SUM_W-VAL_W){smem_rd_q[VAL_W-1]}}, smem_rd_q};
          end
          if (last_p) state_d = S_MSTART;
          else p_d = p_q + 1'b1;
        end
      end
      S_MSTART: begin
        div_start = 1'b1;
        state_d   = S_MDIV;
      end
      S_MDIV: begin
        if (div_done) begin
          mean_we = 1'b1;
          p_d     = '0;
          if (last_j) begin
            found_d = 1'b0;
            state_d = S_MSRCH;
          end else begin
            j_d     = j_q + 1'b1;
            msum_d  = '0;
            state_d = S_MSUM;
          end
        end
      end
      S_MSRCH: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (lbl_rd_q == c_q[CIDX_W-1:0]) begin
            j_d     = '0;
            acc_d   = '0;
            state_d = S_MDST;
          end else if (last_p) begin
            j_d     = '0;
            state_d = S_MCPY;
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      S_MCMP: begin
        if (!found_q || acc_q < bd_q) begin
          found_d  = 1'b1;
          bd_d     = acc_q;
          best_p_d = p_q[PIDX_W-1:0];
        end
        acc_d = '0;
        if (last_p) begin
          j_d     = '0;
          state_d = S_MCPY;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_MSRCH;
        end
      end
      S_OUT: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d                = 1'b0;
          res_valid_d         = 1'b1;
          res_d.point_index   = p_q[PIDX_W-1:0];
          res_d.cluster_label = lbl_rd_q;
          res_d.converged     = conv_q;
          res_d.last          = last_p;
          if (last_p) begin
            load_pos_d  = '0;
            mload_pos_d = '0;
            state_d     = S_IDLE;
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      if (size_clr) size_d[i] = '0;
      else if (size_inc && best_c_q == CIDX_W'(i)) size_d[i] = size_q[i] + 1'b1;
      else size_d[i] = size_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= 1'b0;
      load_pos_q  <= '0;
      mload_pos_q <= '0;
      res_valid_q <= 1'b0;
      p_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      it_q        <= '0;
      first_q     <= 1'b0;
      changed_q   <= 1'b0;
      found_q     <= 1'b0;
      conv_q      <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) size_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      load_pos_q  <= load_pos_d;
      mload_pos_q <= mload_pos_d;
      res_valid_q <= res_valid_d;
      p_q         <= p_d;
      j_q         <= j_d;
      c_q         <= c_d;
      it_q        <= it_d;
      first_q     <= first_d;
      changed_q   <= changed_d;
      found_q     <= found_d;
      conv_q      <= conv_d;
      for (int i = 0; i < MAX_CLUSTERS; i++) size_q[i] <= size_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nf_q       <= nf_d;
    k_q        <= k_d;
    iters_q    <= iters_d;
    raw_addr_q <= raw_addr_d;
    sum_q      <= sum_d;
    sumsq_q    <= sumsq_d;
    msum_q     <= msum_d;
    prod1_q    <= prod1_d;
    prod2_q    <= prod2_d;
    s_q        <= s_d;
    num_q      <= num_d;
    acc_q      <= acc_d;
    bd_q       <= bd_d;
    best_c_q   <= best_c_d;
    best_p_q   <= best_p_d;
    midx_q     <= midx_d;
    res_q      <= res_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= CNT_P_W'(64);
      num_features_q <= CNT_F_W'(8);
      num_clusters_q <= CNT_C_W'(2);
      max_iter_q     <= IT_W'(255);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NUM_POINTS:     num_points_q   <= cfg_data_i[CNT_P_W-1:0];
        REG_NUM_FEATURES:   num_features_q <= cfg_data_i[CNT_F_W-1:0];
        REG_NUM_CLUSTERS:   num_clusters_q <= cfg_data_i[CNT_C_W-1:0];
        REG_MAX_ITERATIONS: max_iter_q     <= cfg_data_i[IT_W-1:0];
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (init_we) init_idx_q[mload_pos_q] <= cmd_i.medoid_point;
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[load_pos_q] <= cmd_i.feature_value;
    raw_rd_q <= raw_mem[raw_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    smem_rd_q <= smem[smem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (med_we) med_mem[cj_addr] <= smem_rd_q;
    med_rd_q <= med_mem[cj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) mean_mem[cj_addr] <= mean_wdata;
    mean_rd_q <= mean_mem[cj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[p_q[PIDX_W-1:0]] <= best_c_q;
    lbl_rd_q <= lbl_mem[p_q[PIDX_W-1:0]];
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/kmc_checker.sv @@
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks on the k-medoids block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_checker
  import kmc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd_i,
  input wire logic result_valid_o,
  input wire res_t result_o
);

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.command == CMD_RUN |=> busy)
    else $error("run transfer did not raise busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy)
    else $error("result outside a run");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy)
    else $error("still busy after final result");

  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> ##2
      (result_valid_o && result_o.point_index == $past(result_o.point_index, 2) + 1'b1))
    else $error("results out of point order");

endmodule

bind kmedoids_clustering kmc_checker u_kmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
